>>> rtl/core/gpio_event_classifier_debounce_queue_unit_defines.svh
// Assertion helpers used by the unit's datapath RTL file.
`ifndef GPIO_EVENT_CLASSIFIER_DEBOUNCE_QUEUE_UNIT_DEFINES_SVH
`define GPIO_EVENT_CLASSIFIER_DEBOUNCE_QUEUE_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define GECDQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define GECDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/gecdq_pkg.sv
package gecdq_pkg;

	// Command codes of the input item.
	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_REG    = 2'd1;
	localparam logic [1:0] MODE_UNREG  = 2'd2;
	localparam logic [1:0] MODE_POP    = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_DISABLED  = 3'd1;
	localparam logic [2:0] ST_MASKED    = 3'd2;
	localparam logic [2:0] ST_DEBOUNCED = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_REGFAIL   = 3'd5;
	localparam logic [2:0] ST_NOTREG    = 3'd6;
	localparam logic [2:0] ST_EMPTY     = 3'd7;

	// Event type codes.
	localparam logic [3:0] EV_LOW  = 4'd1;
	localparam logic [3:0] EV_HIGH = 4'd2;
	localparam logic [3:0] EV_FALL = 4'd4;
	localparam logic [3:0] EV_RISE = 4'd8;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  slot;
		logic        level;
		logic [31:0] now_ms;
		logic [3:0]  event_select;
		logic [31:0] debounce;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] irq_id;
		logic [3:0] ev_code;
	} out_item_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic execute;
	} ctl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic result_ready;
	} dp_stat_t;

	function automatic logic [3:0] classify(input logic prev, input logic cur);
		logic [3:0] t;
		if (prev && !cur)
			t = EV_FALL;
		else if (!prev && cur)
			t = EV_RISE;
		else if (!cur)
			t = EV_LOW;
		else
			t = EV_HIGH;
		return t;
	endfunction

endpackage

>>> rtl/core/gecdq_ctrl.sv
module gecdq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 out_busy,
	output gecdq_pkg::ctl_cmd_t  cmd
);
	import gecdq_pkg::*;

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_EXEC = 1'b1;

	logic [0:0] state_q;

	// Take an item only when idle and the output register is free.
	assign in_stall    = (state_q != S_IDLE) || out_busy;
	assign cmd.capture = in_valid && !in_stall;
	assign cmd.execute = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd.capture) state_q <= S_EXEC;
				S_EXEC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/core/gecdq_dpath.sv
`include "gpio_event_classifier_debounce_queue_unit_defines.svh"
module gecdq_dpath #(
	parameter int SLOTS       = 16,
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gecdq_pkg::ctl_cmd_t   cmd,
	input  gecdq_pkg::in_item_t   in_data,
	output gecdq_pkg::out_item_t  out_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output gecdq_pkg::dp_stat_t   stat
);
	import gecdq_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// Slot table in flops; reset values are known.
	logic [SLOTS-1:0] en_q;
	logic [SLOTS-1:0] lvl_q;
	logic [3:0]       mask_q  [SLOTS];
	logic [31:0]      deb_q   [SLOTS];
	logic [31:0]      ltime_q [SLOTS];
	logic [3:0]       ltype_q [SLOTS];

	logic [8:0]    fifo_mem [QUEUE_DEPTH];
	logic [QW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;

	in_item_t item_q;
	out_item_t res_q;
	out_item_t res_d;
	logic      res_v_q;

	// Stage one: latch the item and fetch the slot entry and queue head.
	logic          en_s1, lvl_s1;
	logic [3:0]    mask_s1, ltype_s1;
	logic [31:0]   deb_s1, ltime_s1;
	logic [8:0]    head_s1;
	logic          free_s1;
	logic [SW-1:0] free_idx_s1;
	logic          slot_ok;
	logic [SW-1:0] sidx;

	// Lowest free slot search over the enable bits.
	logic          free_any;
	logic [SW-1:0] free_idx;
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!en_q[i]) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign slot_ok = ({28'd0, in_data.slot} < 32'(SLOTS));
	assign sidx    = SW'(in_data.slot);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q      <= in_data;
			en_s1       <= slot_ok && en_q[sidx];
			lvl_s1      <= lvl_q[sidx];
			mask_s1     <= mask_q[sidx];
			deb_s1      <= deb_q[sidx];
			ltime_s1    <= ltime_q[sidx];
			ltype_s1    <= ltype_q[sidx];
			head_s1     <= fifo_mem[head_q];
			free_s1     <= free_any;
			free_idx_s1 <= free_idx;
		end
	end

	// Stage two: decide and write back.
	logic [SW-1:0] widx;
	logic [3:0]    ev;
	logic [31:0]   diff;
	logic          bounced, full;
	assign widx    = SW'(item_q.slot);
	assign ev      = classify(lvl_s1, item_q.level);
	assign diff    = item_q.now_ms - ltime_s1;
	assign bounced = (deb_s1 != 32'd0) && (diff < deb_s1) && (ev == ltype_s1);
	assign full    = (count_q >= CW'(QUEUE_DEPTH));

	logic [4:0] push_id;
	assign push_id = 5'(item_q.slot) + 5'd1;

	always_ff @(posedge clk) begin
		if (cmd.execute && item_q.mode == MODE_SAMPLE && en_s1
				&& (ev & mask_s1) != 4'd0 && !bounced && !full)
			fifo_mem[tail_q] <= {push_id, ev};
	end

	// Result of the item in stage two.
	always_comb begin
		res_d = '{status: ST_OK, irq_id: 5'd0, ev_code: 4'd0};
		unique case (item_q.mode)
			MODE_SAMPLE: begin
				if (!en_s1) begin
					res_d.status = ST_DISABLED;
				end else begin
					res_d.ev_code = ev;
					if ((ev & mask_s1) == 4'd0)
						res_d.status = ST_MASKED;
					else if (bounced)
						res_d.status = ST_DEBOUNCED;
					else if (full)
						res_d.status = ST_FULL;
				end
			end
			MODE_REG: begin
				if (item_q.event_select == 4'd0 || !free_s1)
					res_d.status = ST_REGFAIL;
				else
					res_d.irq_id = 5'(free_idx_s1) + 5'd1;
			end
			MODE_UNREG: begin
				if (!en_s1)
					res_d.status = ST_NOTREG;
			end
			MODE_POP: begin
				if (count_q == '0) begin
					res_d.status = ST_EMPTY;
				end else begin
					res_d.irq_id  = head_s1[8:4];
					res_d.ev_code = head_s1[3:0];
				end
			end
			default: res_d.status = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= '0;
			lvl_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			res_v_q <= 1'b0;
			res_q   <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				mask_q[i]  <= '0;
				deb_q[i]   <= '0;
				ltime_q[i] <= '0;
				ltype_q[i] <= '0;
			end
		end else begin
			if (cmd.execute)
				res_v_q <= 1'b1;
			else if (res_v_q && !out_stall)
				res_v_q <= 1'b0;
			if (cmd.execute) begin
				res_q <= res_d;
				unique case (item_q.mode)
					MODE_SAMPLE: begin
						if (en_s1) begin
							lvl_q[widx] <= item_q.level;
							if ((ev & mask_s1) != 4'd0 && !bounced) begin
								ltime_q[widx] <= item_q.now_ms;
								ltype_q[widx] <= ev;
								if (!full) begin
									tail_q  <= (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0
										: tail_q + QW'(1);
									count_q <= count_q + CW'(1);
								end
							end
						end
					end
					MODE_REG: begin
						if (item_q.event_select != 4'd0 && free_s1) begin
							en_q[free_idx_s1]    <= 1'b1;
							lvl_q[free_idx_s1]   <= item_q.level;
							mask_q[free_idx_s1]  <= item_q.event_select;
							deb_q[free_idx_s1]   <= item_q.debounce;
							ltime_q[free_idx_s1] <= '0;
							ltype_q[free_idx_s1] <= '0;
							head_q  <= '0;
							tail_q  <= '0;
							count_q <= '0;
						end
					end
					MODE_UNREG: begin
						if (en_s1) begin
							en_q[widx]    <= 1'b0;
							lvl_q[widx]   <= 1'b0;
							mask_q[widx]  <= '0;
							deb_q[widx]   <= '0;
							ltime_q[widx] <= '0;
							ltype_q[widx] <= '0;
						end
					end
					MODE_POP: begin
						if (count_q != '0) begin
							head_q  <= (head_q == QW'(QUEUE_DEPTH - 1)) ? '0
								: head_q + QW'(1);
							count_q <= count_q - CW'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign out_data          = res_q;
	assign out_valid         = res_v_q;
	assign stat.result_ready = res_v_q;

	`GECDQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(QUEUE_DEPTH),
		"queue count beyond depth")
	`GECDQ_ASSERT_NEXT(a_exec_result, clk, arst_n, cmd.execute, res_v_q,
		"no result after execute")
	`GECDQ_ASSERT_IMP(a_no_cap_exec, clk, arst_n, cmd.execute, !cmd.capture,
		"capture during execute")
endmodule

>>> rtl/core/gpio_event_classifier_debounce_queue_unit.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_stall   | gecdq_pkg::in_item_t
// out     | output    | out_valid/out_stall | gecdq_pkg::out_item_t
// An item is captured at one edge (slot entry and queue head read) and executed
// at the next (written back); its result is presented from that edge on.
// The next item is taken only once the result beat has been accepted, so items
// are never overlapped; a stalled output holds off the next item further.
// The output register holds one result; a stalled result blocks new items.
// Reset clears all slots and empties the queue at once; no clearing pass.
module gpio_event_classifier_debounce_queue_unit #(
	parameter int SLOTS       = 16,
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  gecdq_pkg::in_item_t   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output gecdq_pkg::out_item_t  out_data
);
	import gecdq_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	gecdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_busy (stat.result_ready),
		.cmd      (cmd)
	);

	gecdq_dpath #(.SLOTS(SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat)
	);
endmodule
